### hdl/bcmm_pkg.sv
// Shared types and constants for the banked cartridge memory mapper.
`timescale 1ns / 1ps

package bcmm_pkg;

   // Request function codes carried in req_tuser
   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_LOAD  = 2'd2
   } func_type;

   // Source of the byte returned by a read
   typedef enum logic [1:0] {
      SRC_ZERO = 2'd0,
      SRC_RAM  = 2'd1,
      SRC_ROM  = 2'd2
   } src_type;

   // Address map, decoded from address[15:14]
   localparam logic [1:0] REGION_BIOS = 2'b00;  // 0x0000-0x3FFF
   localparam logic [1:0] REGION_RAM  = 2'b11;  // 0xC000-0xFFFF

   localparam int          WIN_OFF_W = 13;       // 8 KB window
   localparam int          RAM_AW    = 14;       // 16 KB work RAM
   localparam int          RAM_DEPTH = 16384;
   localparam logic [2:0]  WIN_FIRST = 3'd2;     // address[15:13] of the 0x4000 window

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int ROM_IDX_W  = 17;
   localparam int REQ_TDATA_W = 48;

endpackage

### hdl/banked_cartridge_memory_mapper.sv
// Top level of the banked cartridge memory mapper.
`timescale 1ns / 1ps

// Four 8 KB ROM windows at 0x4000/0x6000/0x8000/0xA000, 16 KB work RAM at 0xC000,
// and a BIOS area below 0x4000 that reads as zero. A write into a window picks
// that window's bank (data modulo BANK_COUNT); a write into RAM stores the byte;
// a load request writes one byte of the ROM store at rom_index (ignored when
// out of range). Only reads produce a response. A request can be accepted every
// cycle; the input stalls only while the RAM clear runs or while a read sits in
// the read stage behind a full output register that rsp is not draining. A read's
// memory access is registered into the read stage at acceptance, and its byte
// moves into the output register once that register is free, which raises
// rsp_tvalid. Writes, loads and unused function codes complete at acceptance.
// After reset a clearing pass zeroes the work RAM one byte per cycle, and
// req_tready stays low until the pass is done. ROM bytes read before any load
// has written them are undefined.
module banked_cartridge_memory_mapper #(
   parameter int BANK_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [bcmm_pkg::REQ_TDATA_W-1:0] req_tdata,   // [15:0] address, [23:16] data,
                                                         // [40:24] rom_index
   input  logic [1:0]  req_tuser,   // [1:0] func
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [7:0] read_data
);

   localparam int BANK_W    = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int ROM_DEPTH = BANK_COUNT * 8192;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int MOD_SIZE  = 256;

   // ---------------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------------
   logic [bcmm_pkg::ADDR_W-1:0]    req_address;
   logic [bcmm_pkg::DATA_W-1:0]    req_data;
   logic [bcmm_pkg::ROM_IDX_W-1:0] req_rom_index;
   bcmm_pkg::func_type             req_func;

   assign req_address   = req_tdata[15:0];
   assign req_data      = req_tdata[23:16];
   assign req_rom_index = req_tdata[40:24];
   assign req_func      = bcmm_pkg::func_type'(req_tuser);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic [BANK_W-1:0]             bank_select_ff [4];
   logic [bcmm_pkg::DATA_W-1:0]   work_ram [bcmm_pkg::RAM_DEPTH];
   logic [bcmm_pkg::DATA_W-1:0]   rom_store [ROM_DEPTH];

   logic [bcmm_pkg::RAM_AW:0]     clear_cnt_ff;   // MSB set once RAM clear is done
   logic                          clear_busy;

   // read stage: registered memory data plus its source
   logic                          s1_valid_ff;
   bcmm_pkg::src_type             s1_src_ff;
   logic [bcmm_pkg::DATA_W-1:0]   ram_q_ff;
   logic [bcmm_pkg::DATA_W-1:0]   rom_q_ff;

   // output register
   logic                          rsp_valid_ff;
   logic [bcmm_pkg::DATA_W-1:0]   rsp_data_ff;

   // bank number modulo BANK_COUNT, a constant table indexed by the data byte
   logic [BANK_W-1:0]             bank_mod [MOD_SIZE];

   for (genvar g = 0; g < MOD_SIZE; g++) begin : g_bank_mod
      assign bank_mod[g] = BANK_W'(g % BANK_COUNT);
   end

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   logic out_free;
   logic s1_advance;
   logic req_accept;

   assign clear_busy = ~clear_cnt_ff[bcmm_pkg::RAM_AW];
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign s1_advance = s1_valid_ff & out_free;
   // the read stage can take a new request when empty or draining this cycle
   assign req_tready = ~clear_busy & (~s1_valid_ff | out_free);
   assign req_accept = req_tvalid & req_tready;

   // ---------------------------------------------------------------------
   // Address decode
   // ---------------------------------------------------------------------
   logic [1:0]                    region;
   logic                          in_bios;
   logic                          in_ram;
   logic [1:0]                    win;
   logic [bcmm_pkg::WIN_OFF_W-1:0] win_off;
   logic [bcmm_pkg::RAM_AW-1:0]   ram_addr;
   logic [ROM_AW-1:0]             rom_rd_idx;
   logic [ROM_AW-1:0]             rom_wr_idx;
   logic                          load_in_range;

   assign region   = req_address[15:14];
   assign in_bios  = (region == bcmm_pkg::REGION_BIOS);
   assign in_ram   = (region == bcmm_pkg::REGION_RAM);
   assign win      = 2'(req_address[15:13] - bcmm_pkg::WIN_FIRST);
   assign win_off  = req_address[bcmm_pkg::WIN_OFF_W-1:0];
   assign ram_addr = req_address[bcmm_pkg::RAM_AW-1:0];
   // bank number is always below BANK_COUNT, so this index stays in range
   assign rom_rd_idx = ROM_AW'({bank_select_ff[win], win_off});
   assign rom_wr_idx = ROM_AW'(req_rom_index);
   assign load_in_range = (32'(req_rom_index) < 32'(ROM_DEPTH));

   logic do_read;
   logic do_write;
   logic do_load;

   always_comb begin
      do_read  = 1'b0;
      do_write = 1'b0;
      do_load  = 1'b0;
      unique case (req_func)
         bcmm_pkg::FUNC_READ:  do_read  = req_accept;
         bcmm_pkg::FUNC_WRITE: do_write = req_accept;
         bcmm_pkg::FUNC_LOAD:  do_load  = req_accept;
         default: ;  // unused code: no effect, no response
      endcase
   end

   logic ram_we;
   logic ram_re;
   logic bank_we;
   logic rom_we;
   logic rom_re;
   logic [bcmm_pkg::RAM_AW-1:0] ram_wr_addr;
   logic [bcmm_pkg::DATA_W-1:0] ram_wr_data;

   assign ram_we  = clear_busy | (do_write & in_ram);
   assign ram_re  = do_read & in_ram;
   assign bank_we = do_write & ~in_bios & ~in_ram;
   assign rom_we  = do_load & load_in_range;
   assign rom_re  = do_read & ~in_bios & ~in_ram;
   // no request is accepted while clearing, so the clear owns the write port
   assign ram_wr_addr = clear_busy ? clear_cnt_ff[bcmm_pkg::RAM_AW-1:0] : ram_addr;
   assign ram_wr_data = clear_busy ? '0 : req_data;

   // ---------------------------------------------------------------------
   // Memories
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ram_we) begin
         work_ram[ram_wr_addr] <= ram_wr_data;
      end
      if (ram_re) begin
         ram_q_ff <= work_ram[ram_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rom_we) begin
         rom_store[rom_wr_idx] <= req_data;
      end
      if (rom_re) begin
         rom_q_ff <= rom_store[rom_rd_idx];
      end
   end

   // ---------------------------------------------------------------------
   // Control and output registers
   // ---------------------------------------------------------------------
   bcmm_pkg::src_type read_src;

   always_comb begin
      priority if (in_bios) begin
         read_src = bcmm_pkg::SRC_ZERO;
      end else if (in_ram) begin
         read_src = bcmm_pkg::SRC_RAM;
      end else begin
         read_src = bcmm_pkg::SRC_ROM;
      end
   end

   logic [bcmm_pkg::DATA_W-1:0] s1_byte;

   always_comb begin
      unique case (s1_src_ff)
         bcmm_pkg::SRC_RAM: s1_byte = ram_q_ff;
         bcmm_pkg::SRC_ROM: s1_byte = rom_q_ff;
         default:           s1_byte = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff   <= '0;
         s1_valid_ff    <= 1'b0;
         s1_src_ff      <= bcmm_pkg::SRC_ZERO;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            bank_select_ff[i] <= '0;
         end
      end else begin
         if (clear_busy) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
         end
         if (bank_we) begin
            bank_select_ff[win] <= bank_mod[req_data];
         end
         // read stage
         if (do_read) begin
            s1_valid_ff <= 1'b1;
            s1_src_ff   <= read_src;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         // output stage
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= s1_byte;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clear_busy |-> !req_tready)
      else $error("request accepted during work RAM clear");

   a_read_enters_stage: assert property (
      @(posedge clock) disable iff (reset) do_read |=> s1_valid_ff)
      else $error("accepted read did not reach the read stage");

   a_stalled_stage_holds: assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_src_ff)))
      else $error("stalled read stage lost its request");

   a_bank_in_range: assert property (
      @(posedge clock) disable iff (reset)
      (32'(bank_select_ff[0]) < BANK_COUNT) && (32'(bank_select_ff[1]) < BANK_COUNT) &&
      (32'(bank_select_ff[2]) < BANK_COUNT) && (32'(bank_select_ff[3]) < BANK_COUNT))
      else $error("bank select out of range");

endmodule
